FILE: rtl/hash_noise_color_texel_top_macros.svh
// Assertion macros for the hash noise color texel block.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef HASH_NOISE_COLOR_TEXEL_TOP_MACROS_SVH
`define HASH_NOISE_COLOR_TEXEL_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define HNCT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define HNCT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HNCT_ASSERT(label, clk, rstn, prop, msg)
`define HNCT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: rtl/hnct_pkg.sv
// Shared types and constants for the hash noise color texel pipeline.
// No dependencies.
`default_nettype none
package hnct_pkg;

    localparam int TEX_SIZE    = 64;
    localparam int COORD_W     = 6;
    localparam int BASE_W      = 16;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int NUM_OCTAVES = 3;
    localparam int NUM_STAGES  = 8;

    // stage register indexes
    localparam int STG_HASH   = 0;
    localparam int STG_MIX    = 1;
    localparam int STG_WEIGHT = 2;
    localparam int STG_NOISE  = 3;
    localparam int STG_CENTER = 4;
    localparam int STG_SCALE  = 5;
    localparam int STG_CLAMP  = 6;
    localparam int STG_BYTE   = 7;

    localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
    localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;

    localparam logic [23:0] Q24_HALF = 24'h800000;
    localparam logic [24:0] Q24_ONE  = 25'h1000000;

    localparam logic [23:0] OCTAVE_WEIGHT [NUM_OCTAVES] =
        '{24'd10066330, 24'd5033165, 24'd1677722};
    localparam int OCTAVE_SHIFT [NUM_OCTAVES] = '{2, 1, 0};

    localparam logic [23:0] LUM_RED   = 24'd5016388;
    localparam logic [23:0] LUM_GREEN = 24'd9848226;
    localparam logic [23:0] LUM_BLUE  = 24'd1912603;

    localparam logic [21:0] AMP_BASE = 22'd1342177;
    localparam logic [19:0] AMP_LUM  = 20'd671089;
    localparam logic [21:0] AMP_MAX  = 22'd2013266;

    localparam logic [BASE_W-1:0] BASE_RESET = 16'd52428;

    typedef enum logic [1:0] {
        REG_RED   = 2'd0,
        REG_GREEN = 2'd1,
        REG_BLUE  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctrl_t;

    typedef struct packed {
        logic [24:0] red;
        logic [24:0] green;
        logic [24:0] blue;
    } color_q24_t;

endpackage
`default_nettype wire

FILE: rtl/hnct_hash_lane.sv
// One octave lane: integer hash of a coordinate pair, then weighting in Q48.
// Depends on hnct_pkg.
`default_nettype none
module hnct_hash_lane (
    input  wire logic                          aclk,
    input  wire hnct_pkg::pipe_ctrl_t          ctrl,
    input  wire logic [hnct_pkg::COORD_W-1:0]  coord_x,
    input  wire logic [hnct_pkg::COORD_W-1:0]  coord_y,
    input  wire logic [23:0]                   weight,
    output logic [47:0]                        prod
);

    logic [31:0] hash_reg;
    logic [31:0] mix_reg;
    logic [47:0] prod_reg;

    logic [31:0] hash_next;
    logic [31:0] mix_next;
    logic [31:0] fold;
    logic [47:0] prod_next;

    always_comb begin
        hash_next = 32'(32'(coord_x) * hnct_pkg::HASH_MUL_X + 32'(coord_y) * hnct_pkg::HASH_MUL_Y);
        mix_next  = 32'((hash_reg ^ (hash_reg >> 13)) * hnct_pkg::HASH_MUL_MIX);
        fold      = mix_reg ^ (mix_reg >> 16);
        prod_next = 48'(fold[23:0]) * 48'(weight);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[hnct_pkg::STG_HASH]) begin
            hash_reg <= hash_next;
        end
        if (ctrl.load[hnct_pkg::STG_MIX]) begin
            mix_reg <= mix_next;
        end
        if (ctrl.load[hnct_pkg::STG_WEIGHT]) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

FILE: rtl/hnct_color_prep.sv
// Base color to Q24, luminance and noise amplitude, five register stages.
// Depends on hnct_pkg.
`default_nettype none
module hnct_color_prep (
    input  wire logic                         aclk,
    input  wire hnct_pkg::pipe_ctrl_t         ctrl,
    input  wire logic [hnct_pkg::BASE_W-1:0]  base_red,
    input  wire logic [hnct_pkg::BASE_W-1:0]  base_green,
    input  wire logic [hnct_pkg::BASE_W-1:0]  base_blue,
    output hnct_pkg::color_q24_t              color,
    output logic [21:0]                       amp24
);

    // c * 2^24 / 65535 rounded; x / 65535 as (x + (x >> 16) + 1) >> 16
    function automatic logic [24:0] to_q24(input logic [hnct_pkg::BASE_W-1:0] c);
        logic [24:0] x;
        logic [24:0] q;
        x = {1'b0, c, 8'h00} + 25'd32767;
        q = (x + (x >> 16) + 25'd1) >> 16;
        return {1'b0, c, 8'h00} + q;
    endfunction

    hnct_pkg::color_q24_t c1_reg, c2_reg, c3_reg, c4_reg, c5_reg;
    logic [47:0] lp_red_reg, lp_green_reg, lp_blue_reg;
    logic [24:0] lum_reg;
    logic [44:0] ap_reg;
    logic [21:0] amp_reg;

    logic [49:0] lum_sum;
    logic [24:0] lum_next;
    logic [44:0] ap_round;
    logic [21:0] amp_next;

    always_comb begin
        lum_sum  = 50'(lp_red_reg) + 50'(lp_green_reg) + 50'(lp_blue_reg)
                 + 50'(hnct_pkg::Q24_HALF);
        lum_next = 25'(lum_sum >> 24);
        ap_round = ap_reg + 45'(hnct_pkg::Q24_HALF);
        amp_next = hnct_pkg::AMP_BASE + 22'(ap_round >> 24);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[hnct_pkg::STG_HASH]) begin
            c1_reg.red   <= to_q24(base_red);
            c1_reg.green <= to_q24(base_green);
            c1_reg.blue  <= to_q24(base_blue);
        end
        if (ctrl.load[hnct_pkg::STG_MIX]) begin
            c2_reg       <= c1_reg;
            lp_red_reg   <= 48'(c1_reg.red) * 48'(hnct_pkg::LUM_RED);
            lp_green_reg <= 48'(c1_reg.green) * 48'(hnct_pkg::LUM_GREEN);
            lp_blue_reg  <= 48'(c1_reg.blue) * 48'(hnct_pkg::LUM_BLUE);
        end
        if (ctrl.load[hnct_pkg::STG_WEIGHT]) begin
            c3_reg  <= c2_reg;
            lum_reg <= lum_next;
        end
        if (ctrl.load[hnct_pkg::STG_NOISE]) begin
            c4_reg <= c3_reg;
            ap_reg <= 45'(lum_reg) * 45'(hnct_pkg::AMP_LUM);
        end
        if (ctrl.load[hnct_pkg::STG_CENTER]) begin
            c5_reg  <= c4_reg;
            amp_reg <= amp_next;
        end
    end

    assign color = c5_reg;
    assign amp24 = amp_reg;

endmodule
`default_nettype wire

FILE: rtl/hnct_channel.sv
// One color channel: round the scaled noise, add, clamp, convert to a byte.
// Depends on hnct_pkg.
`default_nettype none
module hnct_channel (
    input  wire logic                  aclk,
    input  wire hnct_pkg::pipe_ctrl_t  ctrl,
    input  wire logic [24:0]           c24,
    input  wire logic signed [47:0]    d48,
    output logic [7:0]                 byte_out
);

    logic [24:0] v_reg;
    logic [7:0]  byte_reg;

    logic signed [47:0] d_round;
    logic signed [25:0] d24;
    logic signed [26:0] sum;
    logic [24:0]        v_next;
    logic [31:0]        scaled;

    always_comb begin
        d_round = d48 + 48'sd8388608;
        d24     = 26'(d_round >>> 24);
        sum     = $signed({2'b00, c24}) + 27'(d24);
        if (sum < 27'sd0) begin
            v_next = '0;
        end else if (sum > 27'sd16777216) begin
            v_next = hnct_pkg::Q24_ONE;
        end else begin
            v_next = sum[24:0];
        end
        scaled = 32'(v_reg) * 32'd255;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[hnct_pkg::STG_CLAMP]) begin
            v_reg <= v_next;
        end
        if (ctrl.load[hnct_pkg::STG_BYTE]) begin
            byte_reg <= scaled[31:24];
        end
    end

    assign byte_out = byte_reg;

endmodule
`default_nettype wire

FILE: rtl/hash_noise_color_texel_top.sv
// Top level of the hash noise color texel block: APB registers, pipeline control,
// noise sum and scaling. Depends on hnct_pkg, hnct_hash_lane, hnct_color_prep,
// hnct_channel and hash_noise_color_texel_top_macros.svh.
//
//   channel   direction  handshake                     payload
//   apb       in/out     psel penable pwrite pready    paddr pwdata prdata
//   s_        in         s_valid s_ready               s_texel_col s_texel_row
//   m_        out        m_valid m_ready               m_red_byte m_green_byte m_blue_byte
//
// One transaction per cycle sustained while m_ready is high; m_valid is valid_reg[7].
// Eight stages, one multiply or one add-and-round each; the 32-bit hash multiplies set it.
// Reset clears the stage valid bits and restores the base color registers.
// A stalled stage holds its data; bubbles ahead of it still fill, so s_ready drops
// only when every stage is full and m_ready is low.
`default_nettype none
`include "hash_noise_color_texel_top_macros.svh"
module hash_noise_color_texel_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [hnct_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [hnct_pkg::DATA_W-1:0]    pwdata,
    output logic [hnct_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [hnct_pkg::COORD_W-1:0]   s_texel_col,
    input  wire logic [hnct_pkg::COORD_W-1:0]   s_texel_row,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [7:0]                          m_red_byte,
    output logic [7:0]                          m_green_byte,
    output logic [7:0]                          m_blue_byte
);

    localparam int NS = hnct_pkg::NUM_STAGES;

    logic [hnct_pkg::BASE_W-1:0] base_red_reg, base_green_reg, base_blue_reg;
    hnct_pkg::cfg_reg_t          reg_sel;
    logic                        wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = hnct_pkg::cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_red_reg   <= hnct_pkg::BASE_RESET;
            base_green_reg <= hnct_pkg::BASE_RESET;
            base_blue_reg  <= hnct_pkg::BASE_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                hnct_pkg::REG_RED:   base_red_reg   <= pwdata[hnct_pkg::BASE_W-1:0];
                hnct_pkg::REG_GREEN: base_green_reg <= pwdata[hnct_pkg::BASE_W-1:0];
                hnct_pkg::REG_BLUE:  base_blue_reg  <= pwdata[hnct_pkg::BASE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            hnct_pkg::REG_RED:   prdata = 32'(base_red_reg);
            hnct_pkg::REG_GREEN: prdata = 32'(base_green_reg);
            hnct_pkg::REG_BLUE:  prdata = 32'(base_blue_reg);
            default:             prdata = '0;
        endcase
    end

    // pipeline control
    logic [NS-1:0]        valid_reg;
    logic [NS:0]          rdy;
    hnct_pkg::pipe_ctrl_t pipe;

    always_comb begin
        rdy[NS] = m_ready;
        for (int i = NS - 1; i >= 0; i--) begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
        pipe.load = rdy[NS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (rdy[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int i = 1; i < NS; i++) begin
                if (rdy[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = valid_reg[NS-1];

    // octave lanes
    logic [hnct_pkg::COORD_W-1:0] col_m, row_m;
    logic [47:0]                  oct_prod [hnct_pkg::NUM_OCTAVES];

    assign col_m = hnct_pkg::COORD_W'(32'(s_texel_col) % hnct_pkg::TEX_SIZE);
    assign row_m = hnct_pkg::COORD_W'(32'(s_texel_row) % hnct_pkg::TEX_SIZE);

    for (genvar g = 0; g < hnct_pkg::NUM_OCTAVES; g++) begin : g_oct
        hnct_hash_lane u_lane (
            .aclk    (aclk),
            .ctrl    (pipe),
            .coord_x (col_m >> hnct_pkg::OCTAVE_SHIFT[g]),
            .coord_y (row_m >> hnct_pkg::OCTAVE_SHIFT[g]),
            .weight  (hnct_pkg::OCTAVE_WEIGHT[g]),
            .prod    (oct_prod[g])
        );
    end

    hnct_pkg::color_q24_t color5;
    logic [21:0]          amp24;

    hnct_color_prep u_prep (
        .aclk       (aclk),
        .ctrl       (pipe),
        .base_red   (base_red_reg),
        .base_green (base_green_reg),
        .base_blue  (base_blue_reg),
        .color      (color5),
        .amp24      (amp24)
    );

    // noise sum, centering and scaling
    logic [24:0]          n24_reg;
    logic signed [25:0]   nd_reg;
    logic signed [47:0]   d48_reg;
    hnct_pkg::color_q24_t c6_reg;

    logic [49:0]        noise_sum;
    logic signed [25:0] nd_next;
    logic signed [47:0] d48_next;

    always_comb begin
        noise_sum = 50'(oct_prod[0]) + 50'(oct_prod[1]) + 50'(oct_prod[2])
                  + 50'(hnct_pkg::Q24_HALF);
        nd_next   = $signed({1'b0, n24_reg}) - 26'sd8388608;
        d48_next  = 48'(nd_reg) * 48'($signed({1'b0, amp24}));
    end

    always_ff @(posedge aclk) begin
        if (pipe.load[hnct_pkg::STG_NOISE]) begin
            n24_reg <= 25'(noise_sum >> 24);
        end
        if (pipe.load[hnct_pkg::STG_CENTER]) begin
            nd_reg <= nd_next;
        end
        if (pipe.load[hnct_pkg::STG_SCALE]) begin
            d48_reg <= d48_next;
            c6_reg  <= color5;
        end
    end

    hnct_channel u_red (
        .aclk     (aclk),
        .ctrl     (pipe),
        .c24      (c6_reg.red),
        .d48      (d48_reg),
        .byte_out (m_red_byte)
    );

    hnct_channel u_green (
        .aclk     (aclk),
        .ctrl     (pipe),
        .c24      (c6_reg.green),
        .d48      (d48_reg),
        .byte_out (m_green_byte)
    );

    hnct_channel u_blue (
        .aclk     (aclk),
        .ctrl     (pipe),
        .c24      (c6_reg.blue),
        .d48      (d48_reg),
        .byte_out (m_blue_byte)
    );

    `HNCT_ASSERT(a_ready_bubble, aclk, aresetn,
        s_ready == (m_ready || !(&valid_reg)), "s_ready disagrees with pipeline occupancy")
    `HNCT_ASSERT(a_amp_range, aclk, aresetn,
        !valid_reg[hnct_pkg::STG_CENTER] ||
        (amp24 >= hnct_pkg::AMP_BASE && amp24 <= hnct_pkg::AMP_MAX),
        "noise amplitude out of range")
    `HNCT_ASSERT(a_center_range, aclk, aresetn,
        !valid_reg[hnct_pkg::STG_CENTER] ||
        (nd_reg >= -26'sd8388608 && nd_reg <= 26'sd8388609),
        "centered noise out of range")
    `HNCT_ASSERT_NEXT(a_scale_hold, aclk, aresetn,
        valid_reg[hnct_pkg::STG_SCALE] && !rdy[hnct_pkg::STG_CLAMP],
        valid_reg[hnct_pkg::STG_SCALE] && $stable(d48_reg),
        "stalled scale stage lost its transaction")

endmodule
`default_nettype wire

FILE: verif/texel_color_checker.sv
// Texel color checker: tracks the base color registers from APB writes, predicts
// the RGB bytes of every accepted texel and compares them with the result channel.
// Depends on hnct_pkg for port widths.
module texel_color_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hnct_pkg::ADDR_W-1:0]    paddr,
    input  logic [hnct_pkg::DATA_W-1:0]    pwdata,
    input  logic                           pready,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [hnct_pkg::COORD_W-1:0]   s_texel_col,
    input  logic [hnct_pkg::COORD_W-1:0]   s_texel_row,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [7:0]                     m_red_byte,
    input  logic [7:0]                     m_green_byte,
    input  logic [7:0]                     m_blue_byte,
    output int                             fail_count,
    output int                             pending_count
);
    import hnct_pkg::*;

    localparam logic [31:0] MIX_X   = 32'd374761393;
    localparam logic [31:0] MIX_Y   = 32'd668265263;
    localparam logic [31:0] MIX_MUL = 32'd1274126177;

    localparam longint ONE_Q24  = 64'sd16777216;
    localparam longint HALF_Q24 = 64'sd8388608;
    localparam longint W_COARSE = 64'sd10066330;
    localparam longint W_MID    = 64'sd5033165;
    localparam longint W_FINE   = 64'sd1677722;
    localparam longint Y_RED    = 64'sd5016388;
    localparam longint Y_GREEN  = 64'sd9848226;
    localparam longint Y_BLUE   = 64'sd1912603;
    localparam longint AMP_MIN  = 64'sd1342177;
    localparam longint AMP_GAIN = 64'sd671089;
    localparam logic [15:0] COLOR_DEFAULT = 16'd52428;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } texel_rgb_t;

    texel_rgb_t expected_texels [$];
    logic [15:0] red_level;
    logic [15:0] green_level;
    logic [15:0] blue_level;
    int mismatches;

    initial begin
        mismatches    = 0;
        fail_count    = 0;
        pending_count = 0;
    end

    function automatic longint octave_value(input logic [5:0] x, input logic [5:0] y);
        logic [31:0] h;
        logic [31:0] px;
        logic [31:0] py;
        px = x;
        py = y;
        h = px * MIX_X + py * MIX_Y;
        h = (h ^ (h >> 13)) * MIX_MUL;
        h = h ^ (h >> 16);
        return h[23:0];
    endfunction

    function automatic longint to_q24(input logic [15:0] c);
        return (longint'(c) * ONE_Q24 + 32767) / 65535;
    endfunction

    function automatic logic [7:0] channel_byte(input longint c24, input longint dev);
        longint v;
        v = c24 + dev;
        if (v < 0) v = 0;
        if (v > ONE_Q24) v = ONE_Q24;
        return 8'((v * 255) >>> 24);
    endfunction

    function automatic texel_rgb_t predict_texel_color(input logic [5:0] col,
                                                       input logic [5:0] row,
                                                       input logic [15:0] red,
                                                       input logic [15:0] green,
                                                       input logic [15:0] blue);
        longint oct [3];
        longint noise;
        longint r24;
        longint g24;
        longint b24;
        longint lum;
        longint amp;
        longint dev;
        texel_rgb_t rgb;
        // octaves at col/4, col/2, col
        for (int k = 0; k < 3; k++) begin
            oct[k] = octave_value(col >> (2 - k), row >> (2 - k));
        end
        noise = (oct[0] * W_COARSE + oct[1] * W_MID + oct[2] * W_FINE + HALF_Q24) >>> 24;
        r24 = to_q24(red);
        g24 = to_q24(green);
        b24 = to_q24(blue);
        lum = (r24 * Y_RED + g24 * Y_GREEN + b24 * Y_BLUE + HALF_Q24) >>> 24;
        amp = AMP_MIN + ((AMP_GAIN * lum + HALF_Q24) >>> 24);
        // signed round half up
        dev = ((noise - HALF_Q24) * amp + HALF_Q24) >>> 24;
        rgb.red   = channel_byte(r24, dev);
        rgb.green = channel_byte(g24, dev);
        rgb.blue  = channel_byte(b24, dev);
        return rgb;
    endfunction

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        texel_rgb_t want;
        texel_rgb_t pred;
        if (!aresetn) begin
            red_level   = COLOR_DEFAULT;
            green_level = COLOR_DEFAULT;
            blue_level  = COLOR_DEFAULT;
            expected_texels.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_texels.size() == 0) begin
                    $error("result transaction with no texel outstanding");
                    mismatches++;
                end else begin
                    want = expected_texels.pop_front();
                    check_field("red_byte", want.red, m_red_byte);
                    check_field("green_byte", want.green, m_green_byte);
                    check_field("blue_byte", want.blue, m_blue_byte);
                end
            end
            if (s_valid && s_ready) begin
                pred = predict_texel_color(s_texel_col, s_texel_row,
                                           red_level, green_level, blue_level);
                expected_texels.insert(expected_texels.size(), pred);
            end
            if (psel && penable && pwrite && pready) begin
                case (cfg_reg_t'(paddr[ADDR_W-1:2]))
                    REG_RED: begin
                        red_level = pwdata[15:0];
                    end
                    REG_GREEN: begin
                        green_level = pwdata[15:0];
                    end
                    REG_BLUE: begin
                        blue_level = pwdata[15:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        fail_count    <= mismatches;
        pending_count <= expected_texels.size();
    end

endmodule

FILE: verif/hash_noise_color_texel_top_tb.sv
// Testbench top for hash_noise_color_texel_top: clock, reset, APB color setup,
// texel stimulus with idle phases, and the verdict.
// Depends on hnct_pkg, the block's RTL and texel_color_checker.
module hash_noise_color_texel_top_tb;
    import hnct_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int NUM_PHASES     = 6;
    localparam int ITEMS_PER_PHASE = 240;
    localparam int DRAIN_CYCLES   = 16;
    localparam int NUM_DIRECTED   = 12;
    localparam logic [ADDR_W-1:0] ADDR_SPARE = 4'hC;

    localparam logic [5:0] DIR_COL [NUM_DIRECTED] =
        '{6'd0, 6'd63, 6'd0, 6'd63, 6'd1, 6'd2, 6'd3, 6'd4, 6'd31, 6'd32, 6'd42, 6'd21};
    localparam logic [5:0] DIR_ROW [NUM_DIRECTED] =
        '{6'd0, 6'd63, 6'd63, 6'd0, 6'd2, 6'd1, 6'd3, 6'd4, 6'd32, 6'd31, 6'd21, 6'd42};

    logic                aclk;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_valid;
    logic                s_ready;
    logic [COORD_W-1:0]  s_texel_col;
    logic [COORD_W-1:0]  s_texel_row;
    logic                m_valid;
    logic                m_ready;
    logic [7:0]          m_red_byte;
    logic [7:0]          m_green_byte;
    logic [7:0]          m_blue_byte;
    int                  fail_count;
    int                  pending_count;
    int                  src_idle_pct;
    int                  sink_stall_pct;
    int                  cycle_count;

    hash_noise_color_texel_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_texel_col  (s_texel_col),
        .s_texel_row  (s_texel_row),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red_byte   (m_red_byte),
        .m_green_byte (m_green_byte),
        .m_blue_byte  (m_blue_byte)
    );

    texel_color_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_texel_col   (s_texel_col),
        .s_texel_row   (s_texel_row),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red_byte    (m_red_byte),
        .m_green_byte  (m_green_byte),
        .m_blue_byte   (m_blue_byte),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    function automatic logic [ADDR_W-1:0] reg_addr(input cfg_reg_t idx);
        return {idx, 2'b00};
    endfunction

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_base_color(input logic [DATA_W-1:0] red, input logic [DATA_W-1:0] green,
                                  input logic [DATA_W-1:0] blue);
        apb_write(reg_addr(REG_RED), red);
        apb_write(reg_addr(REG_GREEN), green);
        apb_write(reg_addr(REG_BLUE), blue);
    endtask

    task automatic send_texel(input logic [5:0] col, input logic [5:0] row);
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_texel_col <= col;
        s_texel_row <= row;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic stop_and_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
    endtask

    initial begin
        logic [5:0] scan_col;
        logic [5:0] scan_row;
        aresetn        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_valid        = 1'b0;
        s_texel_col    = '0;
        s_texel_row    = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        scan_col       = '0;
        scan_row       = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset color, corners and octave boundaries
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_texel(DIR_COL[i], DIR_ROW[i]);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                stop_and_drain();
                case (phase)
                    1: set_base_color({16'($urandom), 16'h0000}, {16'hFFFF, 16'h0000},
                                      {16'($urandom), 16'h0000});
                    2: set_base_color(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
                    3: begin
                        set_base_color(32'h0000_FFFF, 32'h0000_0000, 32'h0000_8000);
                        apb_write(ADDR_SPARE, 32'hFFFF_FFFF);
                    end
                    4: set_base_color($urandom, $urandom, $urandom);
                    default: begin
                        set_base_color($urandom_range(0, 65535), $urandom_range(0, 65535),
                                       $urandom_range(0, 65535));
                        apb_write(ADDR_SPARE, $urandom);
                    end
                endcase
            end
            case (phase % 4)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 45;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 45;
                end
                default: begin
                    src_idle_pct   = 20;
                    sink_stall_pct = 20;
                end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (phase == 3 && i == ITEMS_PER_PHASE / 2) begin
                    stop_and_drain();
                end
                // half raster scan, half scattered
                if ($urandom_range(0, 1) == 1) begin
                    if (scan_col == 6'd63) scan_row = scan_row + 6'd1;
                    scan_col = scan_col + 6'd1;
                end else begin
                    scan_col = 6'($urandom_range(0, 63));
                    scan_row = 6'($urandom_range(0, 63));
                end
                send_texel(scan_col, scan_row);
            end
        end

        stop_and_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/hnct_pkg.sv
rtl/hnct_hash_lane.sv
rtl/hnct_color_prep.sv
rtl/hnct_channel.sv
rtl/hash_noise_color_texel_top.sv
verif/texel_color_checker.sv
verif/hash_noise_color_texel_top_tb.sv
